>>> src/dec_pkg.sv
// shared types and constants for the delay echo / comb filter block
// no dependencies; used by dec_ctrl, dec_dpath and delay_echo_comb
`default_nettype none

package dec_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register widths
  localparam int LEN_W     = 13;
  localparam int GAIN_W    = 16;
  localparam int FRAC_BITS = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 3'd4;

  // effect modes
  localparam logic MODE_ECHO = 1'b0;
  localparam logic MODE_COMB = 1'b1;

  // register reset values
  localparam logic               MODE_RESET = MODE_ECHO;
  localparam logic [LEN_W-1:0]   LEN_RESET  = 13'd1;
  localparam logic [GAIN_W-1:0]  FB_RESET   = 16'h0000;
  localparam logic [GAIN_W-1:0]  DRY_RESET  = 16'h7fff;
  localparam logic [GAIN_W-1:0]  WET_RESET  = 16'h0000;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch sample, issue line read
    logic mul;     // feedback, dry and delayed-wet products
    logic store;   // saturate stored value, write line, advance position
    logic wet;     // comb mode: wet product of stored value
    logic fin;     // load output register
  } dec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic comb_mode;
  } dec_sts_t;

endpackage

`default_nettype wire

>>> src/dec_ctrl.sv
// controller state machine for the delay echo / comb filter block
// depends on dec_pkg for the command and status structs
`default_nettype none

module dec_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dec_pkg::dec_sts_t sts,
  output dec_pkg::dec_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_STORE,
    S_WET,
    S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   fin_go;

  // output register may be reloaded once the held beat is gone
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept = in_valid && (state_r == S_IDLE);
    cmd.mul    = (state_r == S_MUL);
    cmd.store  = (state_r == S_STORE);
    cmd.wet    = (state_r == S_WET);
    cmd.fin    = fin_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_STORE;
        end
        S_STORE: begin
          if (sts.comb_mode) begin
            state_r <= S_WET;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_WET: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.mul)
    else $error("accepted beat did not start the multiply step");

  a_mul_to_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> cmd.store)
    else $error("multiply step not followed by line store");

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid && in_ready)
    else $error("output load did not present a result and return to idle");
`endif

endmodule

`default_nettype wire

>>> src/dec_dpath.sv
// datapath of the delay echo / comb filter: config registers, delay line
// memory, fill count, multipliers and saturation; depends on dec_pkg
`default_nettype none

module dec_dpath #(
  parameter int MAX_DELAY   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dec_pkg::dec_cmd_t                   cmd,
  output dec_pkg::dec_sts_t                        sts,
  input  wire logic                                cfg_wr_en,
  input  wire logic [dec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dec_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic signed [SAMPLE_BITS-1:0]            out_sample_out
);

  localparam int S  = SAMPLE_BITS;
  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int GW = dec_pkg::GAIN_W;
  localparam int PW = S + GW + 1;            // full product plus headroom
  localparam int RW = PW - dec_pkg::FRAC_BITS; // rounded product
  localparam int SW = RW + 1;                // sum of two terms

  // product rounded to sample scale, halves toward plus infinity
  function automatic logic signed [RW-1:0] round_q(input logic signed [S-1:0]  s,
                                                   input logic signed [GW-1:0] g);
    logic signed [PW-1:0] p;
    begin
      p = PW'(s) * PW'(g);
      p = p + PW'(1 << (dec_pkg::FRAC_BITS - 1));
      return p[PW-1:dec_pkg::FRAC_BITS];
    end
  endfunction

  function automatic logic signed [S-1:0] sat_s(input logic signed [SW-1:0] v);
    logic [SW-S:0] top;
    begin
      top = v[SW-1:S-1];
      if ((top == '0) || (top == '1)) begin
        return v[S-1:0];
      end else if (v[SW-1]) begin
        return {1'b1, {(S-1){1'b0}}};
      end else begin
        return {1'b0, {(S-1){1'b1}}};
      end
    end
  endfunction

  // configuration registers
  logic                           mode_r;
  logic [dec_pkg::LEN_W-1:0]      len_r;
  logic signed [GW-1:0]           fb_r;
  logic signed [GW-1:0]           dry_r;
  logic signed [GW-1:0]           wet_r;

  // line control
  logic [AW-1:0]                  pos_r;
  logic [AW-1:0]                  pos_nxt;
  logic [AW:0]                    fill_r;
  logic [AW:0]                    fill_nxt;
  logic [AW:0]                    len_c;
  logic [AW-1:0]                  pos_eff;
  logic [AW:0]                    inc_c;

  // line memory
  logic signed [S-1:0]            mem [MAX_DELAY];
  logic signed [S-1:0]            rdata_r;

  // item payload
  logic signed [S-1:0]            x_r;
  logic [AW-1:0]                  addr_r;
  logic signed [S-1:0]            d_c;
  logic signed [RW-1:0]           rfb_r;
  logic signed [RW-1:0]           rdry_r;
  logic signed [RW-1:0]           rwet_r;
  logic signed [S-1:0]            stored_c;
  logic signed [S-1:0]            stored_r;
  logic signed [S-1:0]            out_r;

  assign sts.comb_mode  = (mode_r == dec_pkg::MODE_COMB);
  assign out_sample_out = out_r;

  // effective length: zero counts as one, clamp to line depth
  always_comb begin
    if (len_r == '0) begin
      len_c = (AW+1)'(1);
    end else if (32'(len_r) > MAX_DELAY) begin
      len_c = (AW+1)'(MAX_DELAY);
    end else begin
      len_c = (AW+1)'(len_r);
    end
  end

  // restart at zero when the length was cut below the position
  assign pos_eff = ({1'b0, pos_r} >= len_c) ? '0 : pos_r;

  assign inc_c = {1'b0, addr_r} + (AW+1)'(1);

  always_comb begin
    pos_nxt  = (inc_c >= len_c) ? '0 : inc_c[AW-1:0];
    fill_nxt = (inc_c > fill_r) ? inc_c : fill_r;
  end

  // writes always fill a prefix of the line, so entries at or past the
  // fill count have not been written since reset and are read as zero
  assign d_c = ({1'b0, addr_r} < fill_r) ? rdata_r : '0;

  assign stored_c = sat_s(SW'(x_r) + SW'(rfb_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dec_pkg::MODE_RESET;
      len_r  <= dec_pkg::LEN_RESET;
      fb_r   <= dec_pkg::FB_RESET;
      dry_r  <= dec_pkg::DRY_RESET;
      wet_r  <= dec_pkg::WET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dec_pkg::REG_EFFECT_MODE:   mode_r <= cfg_wdata[0];
        dec_pkg::REG_DELAY_LENGTH:  len_r  <= cfg_wdata[dec_pkg::LEN_W-1:0];
        dec_pkg::REG_FEEDBACK_GAIN: fb_r   <= cfg_wdata;
        dec_pkg::REG_DRY_GAIN:      dry_r  <= cfg_wdata;
        dec_pkg::REG_WET_GAIN:      wet_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else if (cmd.store) begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata_r <= mem[pos_eff];
    end
    if (cmd.store) begin
      mem[addr_r] <= stored_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r    <= in_sample_in;
      addr_r <= pos_eff;
    end
    if (cmd.mul) begin
      rfb_r  <= round_q(d_c, fb_r);
      rdry_r <= round_q(x_r, dry_r);
      rwet_r <= round_q(d_c, wet_r);
    end
    if (cmd.store) begin
      stored_r <= stored_c;
    end
    // comb mode replaces the delayed-wet term
    if (cmd.wet) begin
      rwet_r <= round_q(stored_r, wet_r);
    end
    if (cmd.fin) begin
      out_r <= sat_s(SW'(rdry_r) + SW'(rwet_r));
    end
  end

`ifndef ASSERT_OFF
  a_store_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> ({1'b0, addr_r} < fill_r))
    else $error("written line entry not covered by fill count");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fill_r >= $past(fill_r)))
    else $error("fill count went backwards");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> (fill_r <= (AW+1)'(MAX_DELAY)) && ({1'b0, pos_r} < len_c))
    else $error("fill count or position past the line length");
`endif

endmodule

`default_nettype wire

>>> src/delay_echo_comb.sv
// echo mode: each sample steps through accept, multiply, store and output load;
// comb mode adds a second multiply on the saturated stored value after the store;
// the line is read at accept and written at store; the output load waits while a
// held result is not taken, and a finished result sits in an output register while the next sample is taken
// reset (rst_n low, synchronous) restores register defaults and empties the
// line through a fill count, so no clearing pass is needed after reset
`default_nettype none

module delay_echo_comb #(
  parameter int MAX_DELAY   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  input  wire logic                            cfg_wr_en,
  input  wire logic [dec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dec_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  dec_pkg::dec_cmd_t cmd;
  dec_pkg::dec_sts_t sts;

  dec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dec_dpath #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .out_sample_out (out_sample_out)
  );

endmodule

`default_nettype wire
